FILE: design/pidsc_pkg.sv
// Shared types, constants and fixed-point helpers for the PID speed controller.
`timescale 1ns / 1ps

package pidsc_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int DATA_W        = 32;
   localparam int LIMIT_W       = 31;
   localparam int PROD_W        = 2 * DATA_W;
   localparam int ACC_W         = DATA_W + 2;
   localparam int CSR_INDEX_W   = 3;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_GAIN_P         = 3'd0,
      REG_GAIN_I         = 3'd1,
      REG_GAIN_D         = 3'd2,
      REG_INTEGRAL_LIMIT = 3'd3,
      REG_OUTPUT_LIMIT   = 3'd4,
      REG_STEP_TIME      = 3'd5,
      REG_STEP_RATE      = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] gain_p;
      logic signed [DATA_W-1:0] gain_i;
      logic signed [DATA_W-1:0] gain_d;
      logic [LIMIT_W-1:0]       integral_limit;
      logic [LIMIT_W-1:0]       output_limit;
      logic [LIMIT_W-1:0]       step_time;
      logic [LIMIT_W-1:0]       step_rate;
   } cfg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIFF,
      S_MUL_TIME,
      S_MUL_RATE,
      S_MUL_P,
      S_MUL_I,
      S_MUL_D,
      S_SUM_D,
      S_FINISH
   } state_type;

   // Operand pair presented to the shared multiplier.
   typedef enum logic [2:0] {
      MUL_ERR_TIME,
      MUL_DERR_RATE,
      MUL_GAIN_P,
      MUL_GAIN_I,
      MUL_GAIN_D
   } mul_sel_type;

   // What the datapath does with the registered product.
   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_INTEG,
      ACC_DERIV,
      ACC_FIRST,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic        load;
      logic        diff;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   // Saturate a 64-bit signed value to 32 bits.
   function automatic logic signed [DATA_W-1:0] sat_to32(input logic signed [PROD_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v[PROD_W-1:DATA_W-1] == {(DATA_W+1){v[PROD_W-1]}}) begin
         r = v[DATA_W-1:0];
      end else if (v[PROD_W-1]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   // Drop the fraction bits of a full product (floor) and saturate.
   function automatic logic signed [DATA_W-1:0] fx_scale(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] s;
      s = p >>> FRACTION_BITS;
      return sat_to32(s);
   endfunction

   // Clamp to the symmetric range from -lim to +lim.
   function automatic logic signed [DATA_W-1:0] clamp_sym(input logic signed [DATA_W-1:0] v,
                                                          input logic [LIMIT_W-1:0] lim);
      logic signed [DATA_W:0] vx;
      logic signed [DATA_W:0] lx;
      logic signed [DATA_W:0] nx;
      logic signed [DATA_W-1:0] r;
      vx = {v[DATA_W-1], v};
      lx = {2'b00, lim};
      nx = -lx;
      if (vx > lx) begin
         r = lx[DATA_W-1:0];
      end else if (vx < nx) begin
         r = nx[DATA_W-1:0];
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

FILE: design/pidsc_regs.sv
// Configuration register bank of the PID speed controller.
`timescale 1ns / 1ps

module pidsc_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pidsc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pidsc_pkg::DATA_W-1:0]        csr_wdata,
   output pidsc_pkg::cfg_type                  cfg
);
   import pidsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_GAIN_P:         cfg_in.gain_p         = csr_wdata;
            REG_GAIN_I:         cfg_in.gain_i         = csr_wdata;
            REG_GAIN_D:         cfg_in.gain_d         = csr_wdata;
            REG_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_wdata[LIMIT_W-1:0];
            REG_OUTPUT_LIMIT:   cfg_in.output_limit   = csr_wdata[LIMIT_W-1:0];
            REG_STEP_TIME:      cfg_in.step_time      = csr_wdata[LIMIT_W-1:0];
            REG_STEP_RATE:      cfg_in.step_rate      = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= 32'sd65536;
         cfg_ff.gain_i         <= '0;
         cfg_ff.gain_d         <= '0;
         cfg_ff.integral_limit <= '0;
         cfg_ff.output_limit   <= 31'd65536;
         cfg_ff.step_time      <= 31'd65;
         cfg_ff.step_rate      <= 31'd65536000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/pidsc_ctrl.sv
// Sequencer that steps the PID datapath through one control tick.
`timescale 1ns / 1ps

module pidsc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  pidsc_pkg::status_type status,
   output pidsc_pkg::cmd_type    cmd
);
   import pidsc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (req_tvalid) state_in = S_DIFF;
         S_DIFF:     state_in = S_MUL_TIME;
         S_MUL_TIME: state_in = S_MUL_RATE;
         S_MUL_RATE: state_in = S_MUL_P;
         S_MUL_P:    state_in = S_MUL_I;
         S_MUL_I:    state_in = S_MUL_D;
         S_MUL_D:    state_in = S_SUM_D;
         S_SUM_D:    state_in = S_FINISH;
         S_FINISH:   if (status.out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // Each product is registered and consumed in the cycle after its operands are issued.
   always_comb begin
      req_tready  = 1'b0;
      cmd.load    = 1'b0;
      cmd.diff    = 1'b0;
      cmd.mul_sel = MUL_ERR_TIME;
      cmd.acc_op  = ACC_NONE;
      cmd.finish  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_DIFF:     cmd.diff = 1'b1;
         S_MUL_TIME: cmd.mul_sel = MUL_ERR_TIME;
         S_MUL_RATE: begin
            cmd.mul_sel = MUL_DERR_RATE;
            cmd.acc_op  = ACC_INTEG;
         end
         S_MUL_P: begin
            cmd.mul_sel = MUL_GAIN_P;
            cmd.acc_op  = ACC_DERIV;
         end
         S_MUL_I: begin
            cmd.mul_sel = MUL_GAIN_I;
            cmd.acc_op  = ACC_FIRST;
         end
         S_MUL_D: begin
            cmd.mul_sel = MUL_GAIN_D;
            cmd.acc_op  = ACC_ADD;
         end
         S_SUM_D:    cmd.acc_op = ACC_ADD;
         S_FINISH:   cmd.finish = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_single_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.diff, cmd.finish}))
      else $error("more than one phase command active");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("result written while output register is occupied");

   a_load_then_diff: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.diff && !req_tready)
      else $error("accepted request not followed by the difference step");

endmodule

FILE: design/pidsc_dpath.sv
// Datapath of the PID speed controller: shared multiplier, state and output register.
`timescale 1ns / 1ps

module pidsc_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  pidsc_pkg::cfg_type               cfg,
   input  pidsc_pkg::cmd_type               cmd,
   output pidsc_pkg::status_type            status,
   input  logic [2*pidsc_pkg::DATA_W-1:0]   req_tdata,
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pidsc_pkg::DATA_W-1:0]     rsp_tdata
);
   import pidsc_pkg::*;

   logic signed [DATA_W-1:0] ref_ff, meas_ff;
   logic                     clear_ff;
   logic signed [DATA_W-1:0] err_ff, derr_ff, prev_ff, integ_ff, deriv_ff;
   logic signed [DATA_W-1:0] integ_in, prev_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DATA_W-1:0] drive_ff;
   logic                     valid_ff, valid_in;

   logic signed [DATA_W-1:0] op_a, op_b;
   logic signed [DATA_W-1:0] term;
   logic signed [DATA_W:0]   diff_e, diff_d;
   logic signed [DATA_W-1:0] err_c, derr_c, prev_eff;
   logic signed [PROD_W-1:0] integ_sum;
   logic signed [PROD_W-1:0] acc_wide;
   logic signed [DATA_W-1:0] drive_c;

   assign prev_eff = clear_ff ? '0 : prev_ff;
   assign diff_e   = {ref_ff[DATA_W-1], ref_ff} - {meas_ff[DATA_W-1], meas_ff};
   assign err_c    = sat_to32({{(PROD_W-DATA_W-1){diff_e[DATA_W]}}, diff_e});
   assign diff_d   = {err_c[DATA_W-1], err_c} - {prev_eff[DATA_W-1], prev_eff};
   assign derr_c   = sat_to32({{(PROD_W-DATA_W-1){diff_d[DATA_W]}}, diff_d});

   assign term      = fx_scale(prod_ff);
   assign integ_sum = {{(PROD_W-DATA_W){integ_ff[DATA_W-1]}}, integ_ff}
                    + {{(PROD_W-DATA_W){term[DATA_W-1]}}, term};
   assign acc_wide  = {{(PROD_W-ACC_W){acc_ff[ACC_W-1]}}, acc_ff};
   assign drive_c   = clamp_sym(sat_to32(acc_wide), cfg.output_limit);

   always_comb begin
      case (cmd.mul_sel)
         MUL_ERR_TIME: begin
            op_a = err_ff;
            op_b = {1'b0, cfg.step_time};
         end
         MUL_DERR_RATE: begin
            op_a = derr_ff;
            op_b = {1'b0, cfg.step_rate};
         end
         MUL_GAIN_P: begin
            op_a = cfg.gain_p;
            op_b = err_ff;
         end
         MUL_GAIN_I: begin
            op_a = cfg.gain_i;
            op_b = integ_ff;
         end
         MUL_GAIN_D: begin
            op_a = cfg.gain_d;
            op_b = deriv_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      integ_in = integ_ff;
      prev_in  = prev_ff;
      if (cmd.diff) begin
         prev_in = err_c;
         if (clear_ff) begin
            integ_in = '0;
         end
      end else if (cmd.acc_op == ACC_INTEG) begin
         integ_in = clamp_sym(sat_to32(integ_sum), cfg.integral_limit);
      end
   end

   // The output register frees up in the same cycle its result is taken.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.finish) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   assign status.out_free = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         integ_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         prev_ff  <= prev_in;
         integ_ff <= integ_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      if (cmd.load) begin
         ref_ff   <= req_tdata[DATA_W-1:0];
         meas_ff  <= req_tdata[2*DATA_W-1:DATA_W];
         clear_ff <= req_tuser;
      end
      if (cmd.diff) begin
         err_ff  <= err_c;
         derr_ff <= derr_c;
      end
      case (cmd.acc_op)
         ACC_DERIV: deriv_ff <= term;
         ACC_FIRST: acc_ff   <= {{(ACC_W-DATA_W){term[DATA_W-1]}}, term};
         ACC_ADD:   acc_ff   <= acc_ff + {{(ACC_W-DATA_W){term[DATA_W-1]}}, term};
         default: ;
      endcase
      if (cmd.finish) begin
         drive_ff <= drive_c;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = drive_ff;

   a_integ_clamped: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.acc_op == ACC_INTEG) && !$past(reset) |->
         ($signed({integ_ff[DATA_W-1], integ_ff}) <= $signed({2'b00, cfg.integral_limit})) &&
         ($signed({integ_ff[DATA_W-1], integ_ff}) >= -$signed({2'b00, cfg.integral_limit})))
      else $error("integral outside its limit after update");

   a_drive_clamped: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.finish) && !$past(reset) |->
         ($signed({drive_ff[DATA_W-1], drive_ff}) <= $signed({2'b00, cfg.output_limit})) &&
         ($signed({drive_ff[DATA_W-1], drive_ff}) >= -$signed({2'b00, cfg.output_limit})))
      else $error("drive value outside the output limit");

   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_tready |=> valid_ff)
      else $error("pending result dropped");

endmodule

FILE: design/pid_speed_controller_unit.sv
// Top level of the PID speed controller with integral clamp.
`timescale 1ns / 1ps

// One request is one control tick: error = reference - measurement, the integral
// adds error * step_time clamped to +/- integral_limit, the derivative is the error
// change times step_rate, and the drive value is the gain-weighted sum clamped to
// +/- output_limit, all in signed Q16.16 with floored, saturated products. A single
// shared 32x32 multiplier forms the five products one per cycle; after acceptance a
// request steps through the difference, the five products and the final sum, and its
// result is written to the output register once that register is free. The next
// request is accepted after that. A result waiting in the output register does not
// stop the next request from being accepted and worked on. Configuration writes are
// taken at once and must be made while no request is in flight; unused indexes are
// ignored.
module pid_speed_controller_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // reference_speed [31:0], measured_speed [63:32]
   input  logic        req_tuser,   // clear_state
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // drive_value [31:0]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import pidsc_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   pidsc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pidsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pidsc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the PID speed controller with integral clamp.
`timescale 1ns / 1ps

module tb_top;
   import pidsc_pkg::*;

   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -WORD_MAX - 1;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;
   localparam int NUM_DIRECTED = 18;
   localparam int NUM_PHASES = 8;
   localparam int TICKS_PER_PHASE = 80;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   pid_speed_controller_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   typedef struct packed {
      logic [31:0] ref_spd;
      logic [31:0] meas_spd;
      logic        clr;
      logic        typed;
      logic [31:0] drive;
   } tick_row_type;

   // Controller copy kept by the testbench.
   cfg_type            ctl_cfg;
   logic signed [31:0] last_error;
   logic signed [31:0] integ_error;

   logic [31:0]  drive_expected_q[$];
   int           tick_count;
   int           drive_count;
   int           fault_count;
   int           write_count;
   bit           sender_idles;
   bit           receiver_stalls;
   tick_row_type tick_table [NUM_DIRECTED];

   always #5 clock = ~clock;

   function automatic logic signed [31:0] sat_word(input longint v);
      if (v > WORD_MAX) return 32'h7fff_ffff;
      if (v < WORD_MIN) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // Exact product, floored to the fixed-point grid, then saturated.
   function automatic logic signed [31:0] q_mul(input longint a, input longint b);
      longint p;
      p = a * b;
      return sat_word(p >>> FRACTION_BITS);
   endfunction

   function automatic logic signed [31:0] clamp_mag(input logic signed [31:0] v,
                                                    input logic [30:0] lim);
      longint l;
      l = longint'(lim);
      if (longint'(v) > l) return {1'b0, lim};
      if (longint'(v) < -l) return 32'(-l);
      return v;
   endfunction

   function automatic void reset_controller_copy();
      ctl_cfg.gain_p         = 32'sd65536;
      ctl_cfg.gain_i         = '0;
      ctl_cfg.gain_d         = '0;
      ctl_cfg.integral_limit = '0;
      ctl_cfg.output_limit   = 31'd65536;
      ctl_cfg.step_time      = 31'd65;
      ctl_cfg.step_rate      = 31'd65536000;
      last_error             = '0;
      integ_error            = '0;
   endfunction

   function automatic void apply_reg_write(input logic [2:0] idx, input logic [31:0] data);
      case (idx)
         REG_GAIN_P:         ctl_cfg.gain_p = data;
         REG_GAIN_I:         ctl_cfg.gain_i = data;
         REG_GAIN_D:         ctl_cfg.gain_d = data;
         REG_INTEGRAL_LIMIT: ctl_cfg.integral_limit = data[30:0];
         REG_OUTPUT_LIMIT:   ctl_cfg.output_limit = data[30:0];
         REG_STEP_TIME:      ctl_cfg.step_time = data[30:0];
         REG_STEP_RATE:      ctl_cfg.step_rate = data[30:0];
         default: ;
      endcase
   endfunction

   // One control tick: updates the integral and last error, returns the drive value.
   function automatic logic [31:0] predict_drive(input logic signed [31:0] ref_spd,
                                                 input logic signed [31:0] meas_spd,
                                                 input logic clr);
      logic signed [31:0] err;
      logic signed [31:0] derr;
      logic signed [31:0] deriv;
      logic signed [31:0] gp;
      logic signed [31:0] gi;
      logic signed [31:0] gd;
      longint             acc;
      gp = ctl_cfg.gain_p;
      gi = ctl_cfg.gain_i;
      gd = ctl_cfg.gain_d;
      if (clr) begin
         last_error  = '0;
         integ_error = '0;
      end
      err = sat_word(longint'(ref_spd) - longint'(meas_spd));
      acc = longint'(integ_error) + longint'(q_mul(err, longint'(ctl_cfg.step_time)));
      integ_error = clamp_mag(sat_word(acc), ctl_cfg.integral_limit);
      derr = sat_word(longint'(err) - longint'(last_error));
      deriv = q_mul(derr, longint'(ctl_cfg.step_rate));
      last_error = err;
      acc = longint'(q_mul(gp, err)) + longint'(q_mul(gi, integ_error))
          + longint'(q_mul(gd, deriv));
      return clamp_mag(sat_word(acc), ctl_cfg.output_limit);
   endfunction

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return 32'h0000_0001;
      endcase
   endfunction

   // All tasks below start and end right after a falling edge.
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      apply_reg_write(idx, data);
      write_count++;
   endtask

   task automatic send_tick(input logic [31:0] ref_spd, input logic [31:0] meas_spd,
                            input logic clr, input logic typed, input logic [31:0] drive);
      int          gap;
      logic [31:0] predicted;
      if ($urandom_range(0, 29) == 0) sender_idles = !sender_idles;
      gap = sender_idles ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {meas_spd, ref_spd};
      req_tuser  = clr;
      do @(posedge clock); while (!req_tready);
      predicted = predict_drive(ref_spd, meas_spd, clr);
      drive_expected_q.push_back(typed ? drive : predicted);
      tick_count++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (drive_expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_setting(input cfg_type c, input bit scramble);
      write_reg(REG_GAIN_P, c.gain_p);
      write_reg(REG_GAIN_I, c.gain_i);
      write_reg(REG_GAIN_D, c.gain_d);
      write_reg(REG_INTEGRAL_LIMIT, {scramble & 1'($urandom), c.integral_limit});
      write_reg(REG_OUTPUT_LIMIT, {scramble & 1'($urandom), c.output_limit});
      write_reg(REG_STEP_TIME, {scramble & 1'($urandom), c.step_time});
      write_reg(REG_STEP_RATE, {scramble & 1'($urandom), c.step_rate});
   endtask

   function automatic logic [31:0] random_gain();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
   endfunction

   function automatic logic [30:0] random_mag(input int small_bits);
      if ($urandom_range(0, 3) == 0) return 31'($urandom);
      return 31'($urandom_range(0, 1 << small_bits));
   endfunction

   function automatic cfg_type phase_setting(input int phase);
      cfg_type c;
      c.gain_p         = 32'sd131072;
      c.gain_i         = 32'sd32768;
      c.gain_d         = 32'sd655;
      c.integral_limit = 31'd6553600;
      c.output_limit   = 31'd65536000;
      c.step_time      = 31'd65;
      c.step_rate      = 31'd65536000;
      case (phase)
         0: begin
            c.gain_p = 32'h7fff_ffff;
            c.gain_i = 32'h7fff_ffff;
            c.gain_d = 32'h7fff_ffff;
            c.integral_limit = '1;
            c.output_limit   = '1;
            c.step_time      = '1;
            c.step_rate      = '1;
         end
         1: begin
            c.gain_p = 32'h8000_0000;
            c.gain_i = 32'h8000_0000;
            c.gain_d = 32'h8000_0000;
            c.integral_limit = '0;
            c.output_limit   = '1;
            c.step_time      = '1;
            c.step_rate      = '0;
         end
         2: c.output_limit = '0;
         3: ;
         default: begin
            c.gain_p         = random_gain();
            c.gain_i         = random_gain();
            c.gain_d         = random_gain();
            c.integral_limit = random_mag(26);
            c.output_limit   = random_mag(28);
            c.step_time      = random_mag(12);
            c.step_rate      = random_mag(26);
         end
      endcase
      return c;
   endfunction

   task automatic send_random_tick();
      logic [31:0] ref_spd;
      logic [31:0] meas_spd;
      int          kind;
      kind    = $urandom_range(0, 9);
      ref_spd = $urandom;
      if (kind < 2) begin
         meas_spd = $urandom;
      end else if (kind < 8) begin
         // Measurement tracks the reference, so the integral builds up gradually.
         meas_spd = ref_spd + 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      end else begin
         ref_spd  = pick_extreme();
         meas_spd = pick_extreme();
      end
      send_tick(ref_spd, meas_spd, $urandom_range(0, 15) == 0, 1'b0, '0);
   endtask

   // Result side: random back-pressure and the comparison against the oldest request.
   initial begin
      int          stall;
      logic [31:0] want;
      rsp_tready = 1'b0;
      receiver_stalls = 1'b1;
      @(negedge reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) receiver_stalls = !receiver_stalls;
         stall = receiver_stalls ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         drive_count++;
         if (drive_expected_q.size() == 0) begin
            $display("%0t ns: drive value 0x%08h arrived with no request outstanding",
                     $time, rsp_tdata);
            fault_count++;
         end else begin
            want = drive_expected_q.pop_front();
            if (rsp_tdata !== want) begin
               $display("%0t ns: drive_value mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
                        $time, $signed(want), want, $signed(rsp_tdata), rsp_tdata);
               fault_count++;
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      cfg_type setting;
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_we      = 1'b0;
      csr_index   = REG_GAIN_P;
      csr_wdata   = '0;
      tick_count  = 0;
      drive_count = 0;
      fault_count = 0;
      write_count = 0;
      sender_idles = 1'b1;
      reset_controller_copy();

      // Reset gains make the drive value the error itself, clamped to +/- 1.0.
      tick_table = '{
         '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
         '{32'h0000_8000, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_8000},
         '{32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b1, 32'h0001_0000},
         '{32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b1, 32'hffff_0000},
         '{32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1, 32'h0000_0000},
         '{32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b1, 32'h0000_0000},
         '{32'hffff_ffff, 32'h0000_0000, 1'b0, 1'b1, 32'hffff_ffff},
         '{32'h0000_0000, 32'h0002_0000, 1'b0, 1'b1, 32'hffff_0000},
         '{32'h0001_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h0001_0000},
         '{32'h0001_0001, 32'h0000_0000, 1'b0, 1'b1, 32'h0001_0000},
         '{32'hffff_0000, 32'h0000_0000, 1'b0, 1'b1, 32'hffff_0000},
         '{32'h0000_3039, 32'h0000_0159, 1'b1, 1'b1, 32'h0000_2ee0},
         '{32'h8000_0000, 32'h0000_0001, 1'b0, 1'b1, 32'hffff_0000},
         '{32'h7fff_ffff, 32'hffff_ffff, 1'b0, 1'b1, 32'h0001_0000},
         '{32'h0000_0007, 32'h0000_0003, 1'b1, 1'b1, 32'h0000_0004},
         '{32'h1234_5678, 32'h0fed_cba9, 1'b0, 1'b0, 32'h0000_0000},
         '{32'haaaa_5555, 32'h5555_aaaa, 1'b1, 1'b0, 32'h0000_0000},
         '{32'h0000_ffff, 32'h0001_0000, 1'b0, 1'b0, 32'h0000_0000}
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (tick_table[i]) begin
         send_tick(tick_table[i].ref_spd, tick_table[i].meas_spd, tick_table[i].clr,
                   tick_table[i].typed, tick_table[i].drive);
      end
      drain();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         setting = phase_setting(phase);
         write_setting(setting, phase >= 4);
         // A write to an index with no register behind it must change nothing.
         if (phase == 2) write_reg(REG_UNUSED, 32'hffff_ffff);
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            if (phase == 3 && n == TICKS_PER_PHASE / 2) drain();
            send_random_tick();
         end
         drain();
      end

      repeat (20) @(posedge clock);
      $display("Ran %0d control ticks (%0d directed) and checked %0d drive values;",
               tick_count, NUM_DIRECTED, drive_count);
      $display("%0d register writes over %0d settings, saturating and zero limits included.",
               write_count, NUM_PHASES + 1);
      if (fault_count == 0 && drive_expected_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
